/* sv/fmr_pkg.sv */
// ----------------------------------------------------------------------------
// fmr_pkg: shared definitions for the framed message receiver
// Buffer geometry, request codes, register indexes, state types and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package fmr_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int IN_DATA_W    = 8;
    localparam int IN_USER_W    = 3;
    localparam int OUT_DATA_W   = 40;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 8;

    // Request codes carried in the input tuser field.
    localparam logic [IN_USER_W-1:0] REQ_BYTE  = 3'd0;
    localparam logic [IN_USER_W-1:0] REQ_REARM = 3'd1;
    localparam logic [IN_USER_W-1:0] REQ_RD1   = 3'd2;
    localparam logic [IN_USER_W-1:0] REQ_RD2   = 3'd3;
    localparam logic [IN_USER_W-1:0] REQ_RD4   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] START_RST  = 8'd2;
    localparam logic [CFG_DATA_W-1:0] STOP_RST   = 8'd3;
    localparam logic [CFG_DATA_W-1:0] ESCAPE_RST = 8'd16;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_STARTING = 4'b0010,
        PH_STARTED  = 4'b0100,
        PH_STOPPING = 4'b1000
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_STORE = 6'b000100,
        S_READ  = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    typedef struct packed {
        logic latch;
        logic parse;
        logic rearm;
        logic rd_check;
        logic rd_issue;
        logic store;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic req_byte;
        logic req_rearm;
        logic req_read;
        logic store_pend;
        logic rd_more;
        logic out_free;
    } t_stat;

endpackage

/* sv/fmr_ctrl.sv */
// ----------------------------------------------------------------------------
// fmr_ctrl: request sequencer
// Accepts one request, steps the datapath through parsing and buffer writes,
// a rearm or buffer reads, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fmr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fmr_pkg::t_stat i_stat,
    output fmr_pkg::t_cmd  o_cmd
);

    fmr_pkg::t_state r_state;
    fmr_pkg::t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            fmr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = fmr_pkg::S_EXEC;
                end
            end
            fmr_pkg::S_EXEC: begin
                if (i_stat.req_byte) begin
                    o_cmd.parse = 1'b1;
                    n_state     = fmr_pkg::S_STORE;
                end else if (i_stat.req_rearm) begin
                    o_cmd.rearm = 1'b1;
                    n_state     = fmr_pkg::S_DONE;
                end else if (i_stat.req_read) begin
                    o_cmd.rd_check = 1'b1;
                    n_state        = fmr_pkg::S_READ;
                end else begin
                    n_state = fmr_pkg::S_DONE;
                end
            end
            fmr_pkg::S_STORE: begin
                if (i_stat.store_pend) begin
                    o_cmd.store = 1'b1;
                end else begin
                    n_state = fmr_pkg::S_DONE;
                end
            end
            fmr_pkg::S_READ: begin
                // The last fetched byte is merged during the cycle that exits.
                if (i_stat.rd_more) begin
                    o_cmd.rd_issue = 1'b1;
                end else begin
                    n_state = fmr_pkg::S_DONE;
                end
            end
            fmr_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = fmr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fmr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/fmr_dp.sv */
// ----------------------------------------------------------------------------
// fmr_dp: receiver datapath
// Token registers, frame parser, message buffer with its write and read
// pointers, read assembly and the output register.
// ----------------------------------------------------------------------------
module fmr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fmr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [fmr_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [fmr_pkg::IN_USER_W-1:0]     i_in_user,
    input  fmr_pkg::t_cmd                     i_cmd,
    output fmr_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fmr_pkg::OUT_DATA_W-1:0]    o_out_data
);

    logic [7:0] r_mem [fmr_pkg::BUFFER_DEPTH];

    logic [7:0]                    r_start_tok, n_start_tok;
    logic [7:0]                    r_stop_tok, n_stop_tok;
    logic [7:0]                    r_esc_tok, n_esc_tok;
    fmr_pkg::t_phase               r_phase, n_phase;
    logic                          r_esc_pend, n_esc_pend;
    logic [fmr_pkg::CNT_W-1:0]     r_count, n_count;
    logic [fmr_pkg::ADDR_W-1:0]    r_rdpos, n_rdpos;
    logic                          r_ready, n_ready;
    logic                          r_err, n_err;
    logic [2:0]                    r_rd_left, n_rd_left;
    logic                          r_cap_v, n_cap_v;
    logic [1:0]                    r_sq_cnt, n_sq_cnt;
    logic                          r_out_valid, n_out_valid;

    logic [fmr_pkg::IN_USER_W-1:0] r_req, n_req;
    logic [7:0]                    r_byte, n_byte;
    logic [31:0]                   r_acc, n_acc;
    logic [7:0]                    r_sq0, n_sq0;
    logic [7:0]                    r_sq1, n_sq1;
    logic [1:0]                    r_lane, n_lane;
    logic [1:0]                    r_cap_lane, n_cap_lane;
    logic [7:0]                    r_mem_q;
    logic [fmr_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                          wr_en;
    logic                          rd_en;
    logic [fmr_pkg::CNT_W-1:0]     rd_size;
    logic                          rd_ok;

    always_comb begin
        case (r_req)
            fmr_pkg::REQ_RD1: rd_size = fmr_pkg::CNT_W'(1);
            fmr_pkg::REQ_RD2: rd_size = fmr_pkg::CNT_W'(2);
            default:          rd_size = fmr_pkg::CNT_W'(4);
        endcase
        rd_ok = r_ready && !r_err && (r_count >= rd_size);
    end

    always_comb begin
        n_start_tok = r_start_tok;
        n_stop_tok  = r_stop_tok;
        n_esc_tok   = r_esc_tok;
        n_phase     = r_phase;
        n_esc_pend  = r_esc_pend;
        n_count     = r_count;
        n_rdpos     = r_rdpos;
        n_ready     = r_ready;
        n_err       = r_err;
        n_rd_left   = r_rd_left;
        n_cap_v     = i_cmd.rd_issue;
        n_cap_lane  = r_lane;
        n_sq_cnt    = r_sq_cnt;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_byte      = r_byte;
        n_acc       = r_acc;
        n_sq0       = r_sq0;
        n_sq1       = r_sq1;
        n_lane      = r_lane;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fmr_pkg::CFG_START:  n_start_tok = i_cfg_data;
                fmr_pkg::CFG_STOP:   n_stop_tok  = i_cfg_data;
                fmr_pkg::CFG_ESCAPE: n_esc_tok   = i_cfg_data;
                default:             ;
            endcase
        end

        if (i_cmd.latch) begin
            n_req  = i_in_user;
            n_byte = i_in_data;
            n_acc  = '0;
        end

        // Merge the byte fetched in the previous cycle into its lane.
        if (r_cap_v) begin
            n_acc = r_acc | (32'(r_mem_q) << {r_cap_lane, 3'b000});
        end

        if (i_cmd.parse && !r_ready) begin
            unique case (r_phase)
                fmr_pkg::PH_IDLE: begin
                    if (r_byte == r_start_tok) n_phase = fmr_pkg::PH_STARTING;
                end
                fmr_pkg::PH_STARTING: begin
                    n_phase = (r_byte == r_start_tok) ? fmr_pkg::PH_STARTED
                                                      : fmr_pkg::PH_IDLE;
                end
                fmr_pkg::PH_STARTED: begin
                    if (r_byte == r_stop_tok) begin
                        n_phase = fmr_pkg::PH_STOPPING;
                    end else begin
                        n_sq0    = r_byte;
                        n_sq_cnt = 2'd1;
                    end
                end
                fmr_pkg::PH_STOPPING: begin
                    if (r_byte == r_stop_tok) begin
                        n_ready = 1'b1;
                        n_rdpos = '0;
                        n_phase = fmr_pkg::PH_IDLE;
                    end else begin
                        // A lone stop token is data: store it, then this byte.
                        n_sq0    = r_stop_tok;
                        n_sq1    = r_byte;
                        n_sq_cnt = 2'd2;
                        n_phase  = fmr_pkg::PH_STARTED;
                    end
                end
                default: n_phase = fmr_pkg::PH_IDLE;
            endcase
        end

        if (i_cmd.store) begin
            n_sq0    = r_sq1;
            n_sq_cnt = r_sq_cnt - 2'd1;
            if (r_count < fmr_pkg::CNT_W'(fmr_pkg::BUFFER_DEPTH)) begin
                if (r_sq0 != r_esc_tok || r_esc_pend) begin
                    wr_en      = 1'b1;
                    n_count    = r_count + fmr_pkg::CNT_W'(1);
                    n_esc_pend = 1'b0;
                end else begin
                    n_esc_pend = 1'b1;
                end
            end
        end

        if (i_cmd.rearm) begin
            n_phase    = fmr_pkg::PH_IDLE;
            n_esc_pend = 1'b0;
            n_count    = '0;
            n_rdpos    = '0;
            n_ready    = 1'b0;
            n_err      = 1'b0;
        end

        if (i_cmd.rd_check) begin
            if (rd_ok) begin
                n_rd_left = rd_size[2:0];
                n_lane    = '0;
            end else if (r_req == fmr_pkg::REQ_RD1 || (r_ready && !r_err)) begin
                // Multi-byte reads only flag an over-read of a readable frame.
                n_err = 1'b1;
            end
        end

        if (i_cmd.rd_issue) begin
            rd_en     = 1'b1;
            n_rdpos   = r_rdpos + fmr_pkg::ADDR_W'(1);
            n_count   = r_count - fmr_pkg::CNT_W'(1);
            n_rd_left = r_rd_left - 3'd1;
            n_lane    = r_lane + 2'd1;
        end

        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = {5'b00000, (r_count == '0), r_err, r_ready, r_acc};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_tok <= fmr_pkg::START_RST;
            r_stop_tok  <= fmr_pkg::STOP_RST;
            r_esc_tok   <= fmr_pkg::ESCAPE_RST;
            r_phase     <= fmr_pkg::PH_IDLE;
            r_esc_pend  <= 1'b0;
            r_count     <= '0;
            r_rdpos     <= '0;
            r_ready     <= 1'b0;
            r_err       <= 1'b0;
            r_rd_left   <= '0;
            r_cap_v     <= 1'b0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start_tok <= n_start_tok;
            r_stop_tok  <= n_stop_tok;
            r_esc_tok   <= n_esc_tok;
            r_phase     <= n_phase;
            r_esc_pend  <= n_esc_pend;
            r_count     <= n_count;
            r_rdpos     <= n_rdpos;
            r_ready     <= n_ready;
            r_err       <= n_err;
            r_rd_left   <= n_rd_left;
            r_cap_v     <= n_cap_v;
            r_sq_cnt    <= n_sq_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_byte     <= n_byte;
        r_acc      <= n_acc;
        r_sq0      <= n_sq0;
        r_sq1      <= n_sq1;
        r_lane     <= n_lane;
        r_cap_lane <= n_cap_lane;
        r_out_data <= n_out_data;
    end

    // Single-port message buffer with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[fmr_pkg::ADDR_W-1:0]] <= r_sq0;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rdpos];
        end
    end

    assign o_stat.req_byte   = (r_req == fmr_pkg::REQ_BYTE);
    assign o_stat.req_rearm  = (r_req == fmr_pkg::REQ_REARM);
    assign o_stat.req_read   = (r_req == fmr_pkg::REQ_RD1) || (r_req == fmr_pkg::REQ_RD2)
                            || (r_req == fmr_pkg::REQ_RD4);
    assign o_stat.store_pend = (r_sq_cnt != 2'd0);
    assign o_stat.rd_more    = (r_rd_left != 3'd0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* sv/framed_message_receiver_top.sv */
// ----------------------------------------------------------------------------
// framed_message_receiver_top: byte-stuffed frame receiver
// Collects framed serial bytes into a message buffer and serves reads of
// 1, 2 or 4 bytes assembled little-endian.
//
// Usage: each request enters on the s_axis channel, tuser carrying the
// request code and tdata the received byte. Every request yields exactly
// one result on the m_axis channel: read data plus the ready, error and
// empty flags. Token registers are written through the cfg port while no
// request is in flight.
// Sequencing: one request at a time. A rearm or unknown request is latched,
// executed and its result loaded; a byte is parsed and then makes none, one
// or two buffer writes; a read is checked, and a granted one then fetches its
// bytes from the single-port buffer, which returns one byte per cycle.
// Reset: synchronous, active low; tokens return to 2, 3 and 16, the parser
// to idle and the buffer to empty. Buffer contents are not cleared.
// Stall: a finished result waits in the output register; the next request
// is accepted meanwhile and its result waits until that register drains.
// ----------------------------------------------------------------------------
module framed_message_receiver_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fmr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [fmr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [2:0] req_type
    input  logic [fmr_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] read_data, [32] msg_ready, [33] error_flag, [34] is_empty
    output logic [fmr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    fmr_pkg::t_cmd  cmd;
    fmr_pkg::t_stat stat;

    fmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fmr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    // A request is never accepted while the previous one is still in work.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is in work");

    // The sequencer issues at most one datapath command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.latch, cmd.parse, cmd.rearm, cmd.rd_check,
                  cmd.rd_issue, cmd.store, cmd.load_out}))
        else $error("overlapping datapath commands");

    // A result is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over an unaccepted one");

    // Buffer fetches stay within the bytes granted by the read check.
    a_fetch_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_issue |-> stat.rd_more)
        else $error("buffer fetch beyond granted read length");

endmodule
